// File: rtl/core/tcp_rto_estimator_timer_macros.svh
// Assertion macros shared by the retransmission timeout estimator RTL.
`ifndef TCP_RTO_ESTIMATOR_TIMER_MACROS_SVH
`define TCP_RTO_ESTIMATOR_TIMER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TRE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TRE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tcprto_pkg.sv
// Package with the types and constants of the retransmission timeout estimator.
`default_nettype none

package tcprto_pkg;

    localparam int unsigned MS_W   = 20;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned IDX_W  = 2;

    localparam logic [MS_W-1:0] MIN_TIMEOUT_RESET  = MS_W'(200);
    localparam logic [MS_W-1:0] MAX_TIMEOUT_RESET  = MS_W'(60000);
    localparam logic [MS_W-1:0] INIT_TIMEOUT_RESET = MS_W'(1000);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 3'd0,
        OP_BACKOFF = 3'd1,
        OP_ARM     = 3'd2,
        OP_DISARM  = 3'd3,
        OP_QUERY   = 3'd4
    } opcode_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_TIMEOUT  = 2'd0,
        CFG_MAX_TIMEOUT  = 2'd1,
        CFG_INIT_TIMEOUT = 2'd2
    } cfg_index_t;

    // Estimator state and timeout after one RTT sample.
    typedef struct packed {
        logic [MS_W-1:0] srtt;
        logic [MS_W-1:0] rttvar;
        logic [MS_W-1:0] timeout;
    } est_result_t;

endpackage

`default_nettype wire

// File: rtl/core/tcprto_est.sv
// Smoothed RTT and variance update with the clamped timeout computation.
`default_nettype none

module tcprto_est (
    input  wire logic [tcprto_pkg::MS_W-1:0] srtt,
    input  wire logic [tcprto_pkg::MS_W-1:0] rttvar,
    input  wire logic                        est_valid,
    input  wire logic [tcprto_pkg::MS_W-1:0] sample_ms,
    input  wire logic [tcprto_pkg::MS_W-1:0] min_timeout,
    input  wire logic [tcprto_pkg::MS_W-1:0] max_timeout,
    output tcprto_pkg::est_result_t          result
);

    localparam int unsigned W = tcprto_pkg::MS_W;

    logic [W-1:0] diff;
    logic [W+1:0] var_sum;
    logic [W+2:0] srtt_sum;
    logic [W-1:0] srtt_new;
    logic [W-1:0] var_new;
    logic [W+1:0] var4;
    logic [W+2:0] computed;

    always_comb begin
        diff     = (srtt > sample_ms) ? (srtt - sample_ms) : (sample_ms - srtt);
        // 3*var + diff and 7*srtt + rtt, truncated by the shift that follows.
        var_sum  = ({2'b00, rttvar} << 1) + {2'b00, rttvar} + {2'b00, diff};
        srtt_sum = ({3'b000, srtt} << 3) - {3'b000, srtt} + {3'b000, sample_ms};

        if (!est_valid) begin
            srtt_new = sample_ms;
            var_new  = sample_ms >> 1;
        end else begin
            srtt_new = srtt_sum[W+2:3];
            var_new  = var_sum[W+1:2];
        end

        var4 = {var_new, 2'b00};
        if (var4 == '0) begin
            var4 = (W+2)'(1);
        end
        computed = {3'b000, srtt_new} + {1'b0, var4};

        result.srtt   = srtt_new;
        result.rttvar = var_new;
        // A value below the minimum wins over the maximum clamp.
        if (computed < {3'b000, min_timeout}) begin
            result.timeout = min_timeout;
        end else if (computed > {3'b000, max_timeout}) begin
            result.timeout = max_timeout;
        end else begin
            result.timeout = computed[W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tcp_rto_estimator_timer.sv
// Top level of the retransmission timeout estimator and timer.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  s_       | in        | s_tvalid/s_tready  | opcode in tuser, operands in tdata
//  m_       | out       | m_tvalid/m_tready  | timeout, estimates, timer status
//  cfg_     | in        | cfg_valid/cfg_ready| register index and 20-bit data
//
// One request enters the input register per cycle while s_tready is high, and its
// result is registered in the output register once that register is free or being
// read; the operation logic between the two registers computes the result.
// The input register keeps accepting while a result waits, and stalls only when
// both registers are full. Reset is synchronous.
// Configuration writes are held off while a request sits in the input register.
`default_nettype none

`include "tcp_rto_estimator_timer_macros.svh"

module tcp_rto_estimator_timer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [19:0] round trip sample in ms, [51:20] now_ms, [52] queue_nonempty,
    // [53] connection_closed, [55:54] zero
    input  wire logic [55:0] s_tdata,
    // [2:0] opcode
    input  wire logic [2:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [19:0] current_timeout_ms, [39:20] smoothed_rtt_ms, [59:40] rtt_variance_ms,
    // [60] timer_running, [61] timer_expired, [63:62] zero
    output logic [63:0]      m_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int unsigned W  = tcprto_pkg::MS_W;
    localparam int unsigned TW = tcprto_pkg::TIME_W;

    // Input register.
    logic                      in_valid_reg;
    tcprto_pkg::opcode_t       in_op_reg;
    logic [W-1:0]              in_rtt_reg;
    logic [TW-1:0]             in_now_reg;
    logic                      in_pending_reg;
    logic                      in_closed_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [W-1:0]              out_timeout_reg;
    logic [W-1:0]              out_srtt_reg;
    logic [W-1:0]              out_var_reg;
    logic                      out_running_reg;
    logic                      out_expired_reg;

    // Configuration and estimator state.
    logic [W-1:0]              min_reg,      min_next;
    logic [W-1:0]              max_reg,      max_next;
    logic [W-1:0]              srtt_reg,     srtt_next;
    logic [W-1:0]              var_reg,      var_next;
    logic                      est_valid_reg, est_valid_next;
    logic [W-1:0]              timeout_reg,  timeout_next;
    logic                      armed_reg,    armed_next;
    logic [TW-1:0]             deadline_reg, deadline_next;
    logic                      expired_next;

    logic                      advance;
    logic                      cfg_write;
    logic [TW:0]               deadline_sum;
    tcprto_pkg::est_result_t   est;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    // A write must not slip in ahead of a request that was accepted before it.
    assign cfg_ready = !in_valid_reg;
    assign cfg_write = cfg_valid && cfg_ready;

    tcprto_est u_est (
        .srtt        (srtt_reg),
        .rttvar      (var_reg),
        .est_valid   (est_valid_reg),
        .sample_ms   (in_rtt_reg),
        .min_timeout (min_reg),
        .max_timeout (max_reg),
        .result      (est)
    );

    assign deadline_sum = {1'b0, in_now_reg} + {{(TW+1-W){1'b0}}, timeout_reg};

    always_comb begin
        min_next       = min_reg;
        max_next       = max_reg;
        srtt_next      = srtt_reg;
        var_next       = var_reg;
        est_valid_next = est_valid_reg;
        timeout_next   = timeout_reg;
        armed_next     = armed_reg;
        deadline_next  = deadline_reg;
        expired_next   = 1'b0;

        if (advance) begin
            case (in_op_reg)
                tcprto_pkg::OP_SAMPLE: begin
                    srtt_next      = est.srtt;
                    var_next       = est.rttvar;
                    timeout_next   = est.timeout;
                    est_valid_next = 1'b1;
                end
                tcprto_pkg::OP_BACKOFF: begin
                    if (timeout_reg >= max_reg || timeout_reg > (max_reg >> 1)) begin
                        timeout_next = max_reg;
                    end else begin
                        timeout_next = timeout_reg << 1;
                    end
                end
                tcprto_pkg::OP_ARM: begin
                    if (in_pending_reg) begin
                        armed_next    = 1'b1;
                        deadline_next = deadline_sum[TW] ? '1 : deadline_sum[TW-1:0];
                    end else begin
                        armed_next    = 1'b0;
                        deadline_next = '0;
                    end
                end
                tcprto_pkg::OP_DISARM: begin
                    armed_next    = 1'b0;
                    deadline_next = '0;
                end
                tcprto_pkg::OP_QUERY: begin
                    expired_next = !in_closed_reg && armed_reg && (deadline_reg != '0)
                                   && (in_now_reg >= deadline_reg);
                end
                default: begin
                end
            endcase
        end else if (cfg_write) begin
            case (cfg_index)
                tcprto_pkg::CFG_MIN_TIMEOUT:  min_next = cfg_data;
                tcprto_pkg::CFG_MAX_TIMEOUT:  max_next = cfg_data;
                // The initial timeout only matters until the first sample arrives.
                tcprto_pkg::CFG_INIT_TIMEOUT: begin
                    if (!est_valid_reg) begin
                        timeout_next = cfg_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_reg       <= tcprto_pkg::MIN_TIMEOUT_RESET;
            max_reg       <= tcprto_pkg::MAX_TIMEOUT_RESET;
            srtt_reg      <= '0;
            var_reg       <= '0;
            est_valid_reg <= 1'b0;
            timeout_reg   <= tcprto_pkg::INIT_TIMEOUT_RESET;
            armed_reg     <= 1'b0;
            deadline_reg  <= '0;
        end else begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            srtt_reg      <= srtt_next;
            var_reg       <= var_next;
            est_valid_reg <= est_valid_next;
            timeout_reg   <= timeout_next;
            armed_reg     <= armed_next;
            deadline_reg  <= deadline_next;

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg      <= tcprto_pkg::opcode_t'(s_tuser);
            in_rtt_reg     <= s_tdata[19:0];
            in_now_reg     <= s_tdata[51:20];
            in_pending_reg <= s_tdata[52];
            in_closed_reg  <= s_tdata[53];
        end
        if (advance) begin
            out_timeout_reg <= timeout_next;
            out_srtt_reg    <= srtt_next;
            out_var_reg     <= var_next;
            out_running_reg <= armed_next;
            out_expired_reg <= expired_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_expired_reg, out_running_reg,
                       out_var_reg, out_srtt_reg, out_timeout_reg};

    `TRE_ASSERT_IMPLIES(a_idle_deadline_clear, !armed_reg, deadline_reg == '0, "stale deadline")
    `TRE_ASSERT_NEXT(a_estimate_sticky, est_valid_reg, est_valid_reg, "estimate valid dropped")
    `TRE_ASSERT_IMPLIES(a_exp_running, out_valid_reg && out_expired_reg, out_running_reg, "stopped")
    `TRE_ASSERT_IMPLIES(a_ready_when_empty, !out_valid_reg, s_tready, "input stalled while empty")

endmodule

`default_nettype wire

// File: tb/sv/tb_tcp_rto_estimator_timer.sv
// Self-checking testbench for the retransmission timeout estimator with a cycle-free predictor.
module tb_tcp_rto_estimator_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MS_W   = tcprto_pkg::MS_W;
    localparam int TIME_W = tcprto_pkg::TIME_W;
    localparam int OP_W   = tcprto_pkg::OP_W;
    localparam int IDX_W  = tcprto_pkg::IDX_W;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int LATENCY       = 2;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 170;
    localparam int CLOSING_ITEMS = 180;
    localparam int PRINT_LIMIT   = 100;

    localparam logic [MS_W-1:0]   MS_MAX          = '1;
    localparam logic [TIME_W-1:0] TIME_MAX        = '1;
    localparam logic [OP_W-1:0]   OP_FIRST_UNUSED = OP_W'(tcprto_pkg::OP_QUERY + 1);
    localparam logic [OP_W-1:0]   OP_LAST_UNUSED  = '1;

    typedef struct packed {
        logic [MS_W-1:0] timeout;
        logic [MS_W-1:0] srtt;
        logic [MS_W-1:0] rttvar;
        logic            running;
        logic            expired;
    } rto_status_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [55:0]       s_tdata;
    logic [OP_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [63:0]       m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [MS_W-1:0]   cfg_data;

    // Predictor copy of the registers and of the estimator and timer state.
    logic [MS_W-1:0]   reg_min;
    logic [MS_W-1:0]   reg_max;
    logic [MS_W-1:0]   reg_init;
    logic [MS_W-1:0]   est_srtt;
    logic [MS_W-1:0]   est_rttvar;
    logic [MS_W-1:0]   est_timeout;
    logic              est_seeded;
    logic              tmr_armed;
    logic [TIME_W-1:0] tmr_deadline;
    logic [TIME_W-1:0] wall_ms;

    rto_status_t       awaiting_status[$];
    int                err_count    = 0;
    bit                bursts_on    = 1'b1;
    bit                hold_request = 1'b0;

    tcp_rto_estimator_timer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic rto_status_t step_rto(input logic [OP_W-1:0]   op,
                                             input logic [MS_W-1:0]   rtt,
                                             input logic [TIME_W-1:0] now,
                                             input logic              pending,
                                             input logic              closed);
        logic [MS_W-1:0] diff;
        logic [63:0]     wide;
        logic [TIME_W:0] sum;
        rto_status_t     st;
        st.expired = 1'b0;
        case (op)
            tcprto_pkg::OP_SAMPLE: begin
                if (!est_seeded) begin
                    est_srtt   = rtt;
                    est_rttvar = rtt >> 1;
                    est_seeded = 1'b1;
                end else begin
                    // The variance uses the smoothed value from before this sample.
                    diff       = (est_srtt > rtt) ? est_srtt - rtt : rtt - est_srtt;
                    wide       = (64'(est_rttvar) * 3 + 64'(diff)) >> 2;
                    est_rttvar = wide[MS_W-1:0];
                    wide       = (64'(est_srtt) * 7 + 64'(rtt)) >> 3;
                    est_srtt   = wide[MS_W-1:0];
                end
                wide = (est_rttvar == '0) ? 64'd1 : 64'(est_rttvar) << 2;
                wide = wide + 64'(est_srtt);
                // The lower clamp wins when the two limits cross.
                if (wide < 64'(reg_min)) begin
                    wide = 64'(reg_min);
                end else if (wide > 64'(reg_max)) begin
                    wide = 64'(reg_max);
                end
                est_timeout = wide[MS_W-1:0];
            end
            tcprto_pkg::OP_BACKOFF: begin
                if (est_timeout >= reg_max || est_timeout > (reg_max >> 1)) begin
                    est_timeout = reg_max;
                end else begin
                    est_timeout = est_timeout << 1;
                end
            end
            tcprto_pkg::OP_ARM: begin
                if (pending) begin
                    tmr_armed    = 1'b1;
                    sum          = {1'b0, now} + (TIME_W + 1)'(est_timeout);
                    tmr_deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                end else begin
                    tmr_armed    = 1'b0;
                    tmr_deadline = '0;
                end
            end
            tcprto_pkg::OP_DISARM: begin
                tmr_armed    = 1'b0;
                tmr_deadline = '0;
            end
            tcprto_pkg::OP_QUERY: begin
                st.expired = !closed && tmr_armed && tmr_deadline != '0 && now >= tmr_deadline;
            end
            default: begin
            end
        endcase
        st.timeout = est_timeout;
        st.srtt    = est_srtt;
        st.rttvar  = est_rttvar;
        st.running = tmr_armed;
        return st;
    endfunction

    // Writes the three timeout registers in index order; only called while idle.
    task automatic set_timeouts(input logic [MS_W-1:0] lo, input logic [MS_W-1:0] hi,
                                input logic [MS_W-1:0] init_ms);
        tcprto_pkg::cfg_index_t idx;
        logic [MS_W-1:0]        value;
        idx = tcprto_pkg::CFG_MIN_TIMEOUT;
        cfg_valid <= 1'b1;
        repeat (idx.num()) begin
            case (idx)
                tcprto_pkg::CFG_MIN_TIMEOUT: value = lo;
                tcprto_pkg::CFG_MAX_TIMEOUT: value = hi;
                default:                     value = init_ms;
            endcase
            cfg_index <= idx;
            cfg_data  <= value;
            do @(posedge aclk); while (!cfg_ready);
            case (idx)
                tcprto_pkg::CFG_MIN_TIMEOUT: reg_min = value;
                tcprto_pkg::CFG_MAX_TIMEOUT: reg_max = value;
                default: begin
                    reg_init = value;
                    if (!est_seeded) begin
                        est_timeout = value;
                    end
                end
            endcase
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input logic [OP_W-1:0]   op,
                                input logic [MS_W-1:0]   rtt,
                                input logic [TIME_W-1:0] now,
                                input logic              pending,
                                input logic              closed);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, closed, pending, now, rtt};
        do @(posedge aclk); while (!s_tready);
        awaiting_status.insert(awaiting_status.size(),
                               step_rto(op, rtt, now, pending, closed));
    endtask

    task automatic send_random_request();
        logic [OP_W-1:0]   op;
        logic [MS_W-1:0]   rtt;
        logic [TIME_W-1:0] now;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            op = tcprto_pkg::OP_SAMPLE;
        end else if (pick < 45) begin
            op = tcprto_pkg::OP_BACKOFF;
        end else if (pick < 65) begin
            op = tcprto_pkg::OP_ARM;
        end else if (pick < 70) begin
            op = tcprto_pkg::OP_DISARM;
        end else if (pick < 95) begin
            op = tcprto_pkg::OP_QUERY;
        end else begin
            op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        end
        case ($urandom_range(0, 9))
            0:       rtt = '0;
            1:       rtt = MS_MAX;
            2, 3:    rtt = MS_W'($urandom);
            default: rtt = MS_W'($urandom_range(1, 3000));
        endcase
        wall_ms = wall_ms + $urandom_range(0, 400);
        pick = $urandom_range(0, 9);
        // Half the time an armed timer is probed right around its deadline.
        if (tmr_armed && pick < 5) begin
            now = tmr_deadline - 32'd3 + $urandom_range(0, 6);
        end else if (pick == 5) begin
            now = $urandom;
        end else if (pick == 6) begin
            now = TIME_MAX;
        end else if (pick == 7) begin
            now = '0;
        end else begin
            now = wall_ms;
        end
        send_request(op, rtt, now, $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
    endtask

    task automatic wait_until_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (awaiting_status.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (awaiting_status.size() != 0) begin
            note_mismatch("results still outstanding after drain limit");
        end
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic test_initial_timeout_write();
        send_request(tcprto_pkg::OP_QUERY, '0, '0, 1'b0, 1'b0);
        wait_until_drained();
        set_timeouts(tcprto_pkg::MIN_TIMEOUT_RESET, tcprto_pkg::MAX_TIMEOUT_RESET, MS_MAX);
        send_request(tcprto_pkg::OP_QUERY, '0, '0, 1'b0, 1'b0);
        send_request(tcprto_pkg::OP_BACKOFF, '0, '0, 1'b0, 1'b0);
        wait_until_drained();
        // Still unseeded, so the new initial value replaces the backed-off one.
        set_timeouts(tcprto_pkg::MIN_TIMEOUT_RESET, tcprto_pkg::MAX_TIMEOUT_RESET, 20'd1500);
        send_request(tcprto_pkg::OP_QUERY, MS_MAX, TIME_MAX, 1'b1, 1'b1);
        wait_until_drained();
    endtask

    task automatic test_unused_opcodes();
        for (int code = OP_FIRST_UNUSED; code <= OP_LAST_UNUSED; code++) begin
            send_request(OP_W'(code), MS_W'($urandom), $urandom, 1'b1, 1'b0);
        end
        wait_until_drained();
    endtask

    task automatic test_rtt_samples();
        send_request(tcprto_pkg::OP_SAMPLE, '0, '0, 1'b0, 1'b0);
        send_request(tcprto_pkg::OP_SAMPLE, MS_MAX, '0, 1'b0, 1'b0);
        send_request(tcprto_pkg::OP_SAMPLE, '0, '0, 1'b1, 1'b1);
        send_request(tcprto_pkg::OP_SAMPLE, 20'd100, '0, 1'b0, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_backoff_ceiling();
        set_timeouts(tcprto_pkg::MIN_TIMEOUT_RESET, MS_MAX, reg_init);
        repeat (4) send_request(tcprto_pkg::OP_BACKOFF, '0, '0, 1'b0, 1'b0);
        wait_until_drained();
        set_timeouts(tcprto_pkg::MIN_TIMEOUT_RESET, tcprto_pkg::MAX_TIMEOUT_RESET, reg_init);
        send_request(tcprto_pkg::OP_BACKOFF, '0, '0, 1'b0, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_arm_and_expiry();
        send_request(tcprto_pkg::OP_ARM, '0, wall_ms, 1'b0, 1'b0);
        send_request(tcprto_pkg::OP_ARM, '0, TIME_MAX, 1'b1, 1'b0);
        send_request(tcprto_pkg::OP_QUERY, '0, TIME_MAX, 1'b1, 1'b1);
        send_request(tcprto_pkg::OP_QUERY, '0, TIME_MAX, 1'b1, 1'b0);
        send_request(tcprto_pkg::OP_DISARM, '0, TIME_MAX, 1'b1, 1'b0);
        send_request(tcprto_pkg::OP_QUERY, '0, TIME_MAX, 1'b1, 1'b0);
        send_request(tcprto_pkg::OP_ARM, '0, 32'd1000, 1'b1, 1'b0);
        send_request(tcprto_pkg::OP_QUERY, '0, tmr_deadline - 32'd1, 1'b0, 1'b0);
        send_request(tcprto_pkg::OP_QUERY, '0, tmr_deadline, 1'b0, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_min_above_max();
        set_timeouts(20'd5000, 20'd300, reg_init);
        send_request(tcprto_pkg::OP_SAMPLE, 20'd10, '0, 1'b0, 1'b0);
        send_request(tcprto_pkg::OP_BACKOFF, '0, '0, 1'b0, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_input_stall();
        bursts_on    = 1'b0;
        hold_request = 1'b1;
        repeat (16) send_random_request();
        wait_until_drained();
        bursts_on = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_timeouts(tcprto_pkg::MIN_TIMEOUT_RESET, tcprto_pkg::MAX_TIMEOUT_RESET,
                                tcprto_pkg::INIT_TIMEOUT_RESET);
                1: set_timeouts(20'd1, MS_MAX, 20'd1);
                2: set_timeouts(MS_MAX, MS_MAX, MS_MAX);
                3: set_timeouts(20'd1, 20'd1, MS_MAX);
                4: set_timeouts(MS_MAX, 20'd1, 20'd7);
                default: set_timeouts(MS_W'($urandom_range(1, 500)),
                                      MS_W'($urandom_range(1000, 200000)),
                                      MS_W'($urandom_range(1, 5000)));
            endcase
            repeat (PHASE_ITEMS) send_random_request();
            wait_until_drained();
        end
    endtask

    task automatic test_unbroken_stream();
        bursts_on = 1'b0;
        set_timeouts(tcprto_pkg::MIN_TIMEOUT_RESET, tcprto_pkg::MAX_TIMEOUT_RESET,
                     tcprto_pkg::INIT_TIMEOUT_RESET);
        repeat (CLOSING_ITEMS) send_random_request();
        wait_until_drained();
    endtask

    // Receiver: random stalls, one long hold-off on request, steady at the end.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (aresetn && bursts_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        rto_status_t got;
        rto_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.timeout = m_tdata[MS_W-1:0];
            got.srtt    = m_tdata[2*MS_W-1:MS_W];
            got.rttvar  = m_tdata[3*MS_W-1:2*MS_W];
            got.running = m_tdata[3*MS_W];
            got.expired = m_tdata[3*MS_W+1];
            if (awaiting_status.size() == 0) begin
                note_mismatch("result arrived with no request outstanding");
            end else begin
                want = awaiting_status[0];
                awaiting_status.delete(0);
                if (got.timeout !== want.timeout)
                    note_mismatch($sformatf("current_timeout_ms %0d, predicted %0d",
                                            got.timeout, want.timeout));
                if (got.srtt !== want.srtt)
                    note_mismatch($sformatf("smoothed_rtt_ms %0d, predicted %0d",
                                            got.srtt, want.srtt));
                if (got.rttvar !== want.rttvar)
                    note_mismatch($sformatf("rtt_variance_ms %0d, predicted %0d",
                                            got.rttvar, want.rttvar));
                if (got.running !== want.running)
                    note_mismatch($sformatf("timer_running %b, predicted %b",
                                            got.running, want.running));
                if (got.expired !== want.expired)
                    note_mismatch($sformatf("timer_expired %b, predicted %b",
                                            got.expired, want.expired));
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= tcprto_pkg::CFG_MIN_TIMEOUT;
        cfg_data  <= '0;

        reg_min      = tcprto_pkg::MIN_TIMEOUT_RESET;
        reg_max      = tcprto_pkg::MAX_TIMEOUT_RESET;
        reg_init     = tcprto_pkg::INIT_TIMEOUT_RESET;
        est_srtt     = '0;
        est_rttvar   = '0;
        est_seeded   = 1'b0;
        est_timeout  = tcprto_pkg::INIT_TIMEOUT_RESET;
        tmr_armed    = 1'b0;
        tmr_deadline = '0;
        wall_ms      = $urandom;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_initial_timeout_write();
        test_unused_opcodes();
        test_rtt_samples();
        test_backoff_ceiling();
        test_arm_and_expiry();
        test_min_above_max();
        test_input_stall();
        test_random_phases();
        test_unbroken_stream();

        if (err_count == 0) begin
            $display("PASS tcp_rto_estimator_timer");
        end else begin
            $display("FAIL tcp_rto_estimator_timer");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL tcp_rto_estimator_timer");
        $finish;
    end

endmodule
